>>> rtl/assert_macros.svh
// Assertion macros shared by the checker files.
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("hkbd assertion failed");

// Check that cons holds in the cycle after ante.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("hkbd assertion failed");

`endif

>>> rtl/hkbd_pkg.sv
// Shared types, constants and helpers of the boot keyboard report differencer.
// Depends on nothing.
`default_nettype none

package hkbd_pkg;

	localparam int SLOTS       = 6;
	localparam int MOD_BITS    = 8;
	localparam int MIN_USAGE   = 4;
	localparam int EVENTS      = MOD_BITS + 2 * SLOTS;
	localparam int QUEUE_DEPTH = 2;

	typedef logic [7:0] usage_t;
	typedef usage_t [SLOTS-1:0] slots_t;

	typedef struct packed {
		logic [7:0] modifier_bits;
		logic [7:0] key_slot_0;
		logic [7:0] key_slot_1;
		logic [7:0] key_slot_2;
		logic [7:0] key_slot_3;
		logic [7:0] key_slot_4;
		logic [7:0] key_slot_5;
	} report_t;

	typedef struct packed {
		logic [15:0] key_code;
		logic        is_press;
		logic        rollover_error;
		logic        last_event;
	} event_t;

	// One classified report: which events fire plus what is needed to build them.
	// Mask bits: modifier bits first, then releases per stored slot, then presses.
	typedef struct packed {
		logic [EVENTS-1:0] mask;
		logic              err;
		logic [7:0]        mods;
		slots_t            old_slots;
		slots_t            new_slots;
	} job_t;

	// True if any slot holds the given usage.
	function automatic logic has_usage(slots_t s, usage_t u);
		logic hit;
		hit = 1'b0;
		for (int i = 0; i < SLOTS; i++) begin
			hit = hit | (s[i] == u);
		end
		return hit;
	endfunction

endpackage

`default_nettype wire

>>> rtl/hkbd_report_if.sv
// Report channel: valid/ready handshake carrying one keyboard report.
// Depends on hkbd_pkg.
`default_nettype none

interface hkbd_report_if;
	logic              valid;
	logic              ready;
	hkbd_pkg::report_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> rtl/hkbd_event_if.sv
// Event channel: valid/ready handshake carrying one key event.
// Depends on hkbd_pkg.
`default_nettype none

interface hkbd_event_if;
	logic             valid;
	logic             ready;
	hkbd_pkg::event_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> rtl/hkbd_front.sv
// Front end: accepts reports, diffs them against the stored report, builds jobs.
// Depends on hkbd_pkg and hkbd_report_if.
`default_nettype none

module hkbd_front (
	input  wire logic          clk,
	input  wire logic          arst_n,
	hkbd_report_if.sink        report,
	output hkbd_pkg::job_t     job,
	output logic               job_valid,
	input  wire logic          job_ready
);

	logic [7:0]       prev_mods_q;
	hkbd_pkg::slots_t prev_slots_q;

	hkbd_pkg::slots_t new_slots;
	logic             err;
	logic             accept;

	// Unpack the slots and flag rollover error codes
	always_comb begin
		new_slots[0] = report.data.key_slot_0;
		new_slots[1] = report.data.key_slot_1;
		new_slots[2] = report.data.key_slot_2;
		new_slots[3] = report.data.key_slot_3;
		new_slots[4] = report.data.key_slot_4;
		new_slots[5] = report.data.key_slot_5;
		err = 1'b0;
		for (int i = 0; i < hkbd_pkg::SLOTS; i++) begin
			err = err | ((new_slots[i] != '0) &&
				(new_slots[i] < hkbd_pkg::usage_t'(hkbd_pkg::MIN_USAGE)));
		end
	end

	// Classify: modifier changes, releases, presses
	always_comb begin
		job.mods      = report.data.modifier_bits;
		job.err       = err;
		job.old_slots = prev_slots_q;
		job.new_slots = new_slots;
		job.mask      = '0;
		job.mask[hkbd_pkg::MOD_BITS-1:0] = report.data.modifier_bits ^ prev_mods_q;
		for (int i = 0; i < hkbd_pkg::SLOTS; i++) begin
			job.mask[hkbd_pkg::MOD_BITS + i] = (prev_slots_q[i] != '0) &&
				!hkbd_pkg::has_usage(new_slots, prev_slots_q[i]);
			job.mask[hkbd_pkg::MOD_BITS + hkbd_pkg::SLOTS + i] =
				(new_slots[i] >= hkbd_pkg::usage_t'(hkbd_pkg::MIN_USAGE)) &&
				!hkbd_pkg::has_usage(prev_slots_q, new_slots[i]);
		end
	end

	// Reports with no change are taken and dropped
	assign report.ready = job_ready;
	assign accept       = report.valid && job_ready;
	assign job_valid    = report.valid && (|job.mask);

	// Keep the last good report; hold it on rollover error
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_mods_q  <= '0;
			prev_slots_q <= '0;
		end else if (accept && !err) begin
			prev_mods_q  <= report.data.modifier_bits;
			prev_slots_q <= new_slots;
		end
	end

endmodule

`default_nettype wire

>>> rtl/hkbd_queue.sv
// Short job queue between front end and back end.
// Depends on hkbd_pkg.
`default_nettype none

module hkbd_queue #(
	parameter int DEPTH = hkbd_pkg::QUEUE_DEPTH
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire hkbd_pkg::job_t  push_job,
	input  wire logic            push_valid,
	output logic                 push_ready,
	output hkbd_pkg::job_t       pop_job,
	output logic                 pop_valid,
	input  wire logic            pop_ready
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	hkbd_pkg::job_t entry_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign push_ready = (count_q != CNT_W'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_job    = entry_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	// Store the pushed job
	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_job;
		end
	end

	// Advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

>>> rtl/hkbd_back.sv
// Back end: serializes one job into events, one beat per cycle while the output is not stalled, lowest mask bit first.
// Depends on hkbd_pkg and hkbd_event_if.
`default_nettype none

module hkbd_back (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire hkbd_pkg::job_t  job,
	input  wire logic            job_valid,
	output logic                 job_pop,
	hkbd_event_if.source         key_event
);

	hkbd_pkg::job_t              cur_q;
	logic [hkbd_pkg::EVENTS-1:0] rem_q;
	logic                        out_valid_q;
	hkbd_pkg::event_t            out_data_q;

	logic [hkbd_pkg::EVENTS-1:0] low;
	logic                        out_load;
	logic                        emit;
	logic                        last;
	hkbd_pkg::event_t            ev;

	// Pick the lowest pending event
	assign low      = rem_q & (~rem_q + 1'b1);
	assign last     = ((rem_q & ~low) == '0);
	assign out_load = !out_valid_q || key_event.ready;
	assign emit     = (|rem_q) && out_load;
	assign job_pop  = job_valid && (!(|rem_q) || (emit && last));

	// Build the event selected by the one-hot pick
	always_comb begin
		ev.key_code       = '0;
		ev.is_press       = 1'b0;
		ev.rollover_error = cur_q.err;
		ev.last_event     = last;
		for (int i = 0; i < hkbd_pkg::MOD_BITS; i++) begin
			ev.key_code[8 + i] = low[i];
			ev.is_press        = ev.is_press | (low[i] & cur_q.mods[i]);
		end
		for (int i = 0; i < hkbd_pkg::SLOTS; i++) begin
			ev.key_code[7:0] = ev.key_code[7:0] |
				(cur_q.old_slots[i] & {8{low[hkbd_pkg::MOD_BITS + i]}}) |
				(cur_q.new_slots[i] & {8{low[hkbd_pkg::MOD_BITS + hkbd_pkg::SLOTS + i]}});
			ev.is_press = ev.is_press | low[hkbd_pkg::MOD_BITS + hkbd_pkg::SLOTS + i];
		end
	end

	// Load a new job or drop the event just sent
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= '0;
		end else if (job_pop) begin
			rem_q <= job.mask;
		end else if (emit) begin
			rem_q <= rem_q & ~low;
		end
	end

	always_ff @(posedge clk) begin
		if (job_pop) begin
			cur_q <= job;
		end
	end

	// Output register: hold the beat until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_data_q <= ev;
		end
	end

	assign key_event.valid = out_valid_q;
	assign key_event.data  = out_data_q;

endmodule

`default_nettype wire

>>> rtl/hid_boot_keyboard_event_diff_top.sv
// Channel    Dir  Beat
// report     in   one boot keyboard report (modifier byte, six usage slots)
// key_event  out  one key or modifier event with press, error and last flags
//
// A report is taken every cycle while the job queue has room; a report with
// no change is taken and dropped. The back end sends one event per cycle while
// the output is not stalled; the events of a report pass through the queue, the
// back end's job register and the output register. Reset clears the stored report
// at once. Either side may stall: the queue and the output register hold work.
// Depends on hkbd_pkg, hkbd_report_if, hkbd_event_if, hkbd_front, hkbd_queue, hkbd_back.
`default_nettype none

module hid_boot_keyboard_event_diff_top #(
	parameter int QUEUE_DEPTH = hkbd_pkg::QUEUE_DEPTH
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	hkbd_report_if.sink    report,
	hkbd_event_if.source   key_event
);

	hkbd_pkg::job_t front_job;
	logic           front_valid;
	logic           front_ready;
	hkbd_pkg::job_t back_job;
	logic           back_valid;
	logic           back_pop;

	hkbd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.report    (report),
		.job       (front_job),
		.job_valid (front_valid),
		.job_ready (front_ready)
	);

	hkbd_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_job   (front_job),
		.push_valid (front_valid),
		.push_ready (front_ready),
		.pop_job    (back_job),
		.pop_valid  (back_valid),
		.pop_ready  (back_pop)
	);

	hkbd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job       (back_job),
		.job_valid (back_valid),
		.job_pop   (back_pop),
		.key_event (key_event)
	);

endmodule

`default_nettype wire

>>> rtl/hkbd_checker.sv
// Port-level checks on the event channel, bound to the top level.
// Depends on assert_macros.svh and hid_boot_keyboard_event_diff_top.
`default_nettype none
`include "assert_macros.svh"

module hkbd_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        evt_valid,
	input wire logic        evt_ready,
	input wire logic [15:0] evt_code,
	input wire logic        evt_press,
	input wire logic        evt_err,
	input wire logic        evt_last
);

	// A stalled beat stays put
	`ASSERT_NEXT(a_evt_hold, clk, arst_n, evt_valid && !evt_ready, evt_valid && $stable({evt_code, evt_press, evt_err, evt_last}))

	// Modifier events name exactly one modifier bit
	`ASSERT_IMPLIES(a_mod_onehot, clk, arst_n, evt_valid && (evt_code[7:0] == 8'h00), $onehot(evt_code[15:8]))

	// Key events carry a real usage, never an error code
	`ASSERT_IMPLIES(a_key_usage, clk, arst_n, evt_valid && (evt_code[15:8] == 8'h00), evt_code[7:0] >= 8'd4)

endmodule

bind hid_boot_keyboard_event_diff_top hkbd_checker u_hkbd_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.evt_valid (key_event.valid),
	.evt_ready (key_event.ready),
	.evt_code  (key_event.data.key_code),
	.evt_press (key_event.data.is_press),
	.evt_err   (key_event.data.rollover_error),
	.evt_last  (key_event.data.last_event)
);

`default_nettype wire
